[rtl/core/uopf_pkg.sv]
`default_nettype none

package uopf_pkg;

    // parse phase; codes 6 and 7 are never reached and act as the error phase
    typedef enum logic [2:0] {
        PH_SLASH = 3'd0,
        PH_FIRST = 3'd1,
        PH_PATH  = 3'd2,
        PH_QUERY = 3'd3,
        PH_FRAG  = 3'd4,
        PH_ERR   = 3'd5
    } phase_t;

    // percent escape progress
    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_t;

    localparam logic [1:0] SEC_PATH  = 2'd0;
    localparam logic [1:0] SEC_QUERY = 2'd1;
    localparam logic [1:0] SEC_FRAG  = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

    // hex digit value width: one extra bit flags a non-digit
    localparam int unsigned NibW = 4;

    typedef struct packed {
        phase_t          phase;
        esc_t            esc;
        logic [NibW-1:0] high_nibble;
    } state_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] out_byte;
        logic [1:0] section;
        logic       done_res;
        logic       accepted;
    } res_t;

    function automatic logic is_pchar(input logic [7:0] b);
        return (b == CH_BANG) || (b == CH_DOLLAR) || (b inside {[8'h26:8'h2E]}) ||
               (b inside {[8'h30:8'h3B]}) || (b == CH_EQUALS) ||
               (b inside {[8'h40:8'h5A]}) || (b == CH_UNDER) ||
               (b inside {[8'h61:8'h7A]}) || (b == CH_TILDE);
    endfunction

    // msb set when the byte is not a hex digit
    function automatic logic [NibW:0] hex_value(input logic [7:0] b);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (b inside {[8'h30:8'h39]}) begin
                d = b - 8'h30;
            end else if (b inside {[8'h61:8'h66]}) begin
                d = b - 8'h57;
            end else if (b inside {[8'h41:8'h46]}) begin
                d = b - 8'h37;
            end else begin
                d = 8'h10;
            end
            return d[NibW:0];
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/uopf_step.sv]
`default_nettype none

module uopf_step (
    input  wire uopf_pkg::state_t cur,
    input  wire logic [7:0]       in_byte,
    input  wire logic             is_last,
    output uopf_pkg::state_t      nxt,
    output uopf_pkg::res_t        res
);
    import uopf_pkg::*;

    phase_t          ph;
    esc_t            esc;
    logic [NibW-1:0] hn;
    logic            emit;
    logic [7:0]      ob;
    logic [NibW:0]   hv;
    logic            in_path;

    always_comb begin
        ph      = cur.phase;
        esc     = cur.esc;
        hn      = cur.high_nibble;
        emit    = 1'b0;
        ob      = 8'h00;
        hv      = hex_value(in_byte);
        in_path = (cur.phase == PH_FIRST) || (cur.phase == PH_PATH);

        if (!(cur.phase inside {PH_SLASH, PH_FIRST, PH_PATH, PH_QUERY, PH_FRAG})) begin
            ph = PH_ERR;
        end else if (cur.esc != ESC_NONE) begin
            if (hv[NibW]) begin
                ph = PH_ERR;
            end else if (cur.esc == ESC_HIGH) begin
                hn  = hv[NibW-1:0];
                esc = ESC_LOW;
                if (!in_path) begin
                    emit = 1'b1;
                    ob   = in_byte;
                end
            end else begin
                esc  = ESC_NONE;
                emit = 1'b1;
                ob   = in_path ? {cur.high_nibble, hv[NibW-1:0]} : in_byte;
            end
        end else begin
            case (cur.phase)
                PH_SLASH: begin
                    if (in_byte == CH_SLASH) begin
                        emit = 1'b1;
                        ob   = in_byte;
                        ph   = PH_FIRST;
                    end else begin
                        ph = PH_ERR;
                    end
                end
                PH_FIRST, PH_PATH: begin
                    if (is_pchar(in_byte)) begin
                        emit = 1'b1;
                        ob   = in_byte;
                        ph   = PH_PATH;
                    end else if (in_byte == CH_PERCENT) begin
                        esc = ESC_HIGH;
                        ph  = PH_PATH;
                    end else if (in_byte == CH_SLASH) begin
                        // empty first segment may not be followed by a slash
                        if (cur.phase == PH_FIRST) begin
                            ph = PH_ERR;
                        end else begin
                            emit = 1'b1;
                            ob   = in_byte;
                        end
                    end else if (in_byte == CH_QUEST) begin
                        emit = 1'b1;
                        ob   = in_byte;
                        ph   = PH_QUERY;
                    end else if (in_byte == CH_HASH) begin
                        emit = 1'b1;
                        ob   = in_byte;
                        ph   = PH_FRAG;
                    end else begin
                        ph = PH_ERR;
                    end
                end
                default: begin
                    // query or fragment
                    if (is_pchar(in_byte) || in_byte == CH_SLASH || in_byte == CH_QUEST) begin
                        emit = 1'b1;
                        ob   = in_byte;
                    end else if (in_byte == CH_PERCENT) begin
                        esc  = ESC_HIGH;
                        emit = 1'b1;
                        ob   = in_byte;
                    end else if (in_byte == CH_HASH && cur.phase == PH_QUERY) begin
                        emit = 1'b1;
                        ob   = in_byte;
                        ph   = PH_FRAG;
                    end else begin
                        ph = PH_ERR;
                    end
                end
            endcase
        end

        if (ph == PH_ERR) begin
            emit = 1'b0;
            ob   = 8'h00;
            esc  = ESC_NONE;
        end

        res.emit     = emit;
        res.out_byte = ob;
        res.section  = (ph == PH_QUERY) ? SEC_QUERY : (ph == PH_FRAG) ? SEC_FRAG : SEC_PATH;
        res.done_res = is_last;
        res.accepted = is_last && (ph != PH_ERR) && (ph != PH_SLASH) && (esc == ESC_NONE);

        if (is_last) begin
            nxt.phase       = PH_SLASH;
            nxt.esc         = ESC_NONE;
            nxt.high_nibble = '0;
        end else begin
            nxt.phase       = ph;
            nxt.esc         = esc;
            nxt.high_nibble = hn;
        end
    end

endmodule

`default_nettype wire

[rtl/core/uri_origin_form_parser_top.sv]
`default_nettype none

// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | s_in_byte[7:0], s_is_last
// m_      | out       | m_valid / m_ready  | m_emit, m_out_byte[7:0], m_section[1:0],
//         |           |                    | m_done_res, m_accepted
//
// one item per cycle sustained while m_ready stays high; each item gives exactly one result item
// an item passes through the input register, then parse logic into the result register
// the parse state is updated as an item moves from the input to the result register
// aresetn (synchronous, active low) clears valids and returns to the leading-slash phase
// a stall on m_ready holds the result; the input register fills, then s_ready drops

module uri_origin_form_parser_top (
    input  wire  logic       aclk,
    input  wire  logic       aresetn,
    input  wire  logic       s_valid,
    output logic             s_ready,
    input  wire  logic [7:0] s_in_byte,
    input  wire  logic       s_is_last,
    output logic             m_valid,
    input  wire  logic       m_ready,
    output logic             m_emit,
    output logic [7:0]       m_out_byte,
    output logic [1:0]       m_section,
    output logic             m_done_res,
    output logic             m_accepted
);
    import uopf_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parse state
    state_t     st_reg;
    state_t     st_next;

    // result register
    logic       out_valid_reg;
    res_t       out_reg;
    res_t       out_next;

    logic       out_free;
    logic       advance;

    // result register can take an item when empty or being drained
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    uopf_step u_step (
        .cur     (st_reg),
        .in_byte (in_byte_reg),
        .is_last (in_last_reg),
        .nxt     (st_next),
        .res     (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload only loads on an accepted item
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase       <= PH_SLASH;
            st_reg.esc         <= ESC_NONE;
            st_reg.high_nibble <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_emit     = out_reg.emit;
    assign m_out_byte = out_reg.out_byte;
    assign m_section  = out_reg.section;
    assign m_done_res = out_reg.done_res;
    assign m_accepted = out_reg.accepted;

    // a verdict only comes with the last item
    a_accept_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_done_res)
        else $error("accepted without done");

    // an accepted target always ends on an emitted character
    a_accept_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_emit)
        else $error("accepted target with silent last item");

    // silent items carry a zero byte
    a_silent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_emit |-> m_out_byte == 8'h00)
        else $error("byte on a silent item");

    // the last item returns the parser to the leading-slash phase
    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> st_reg.phase == PH_SLASH && st_reg.esc == ESC_NONE)
        else $error("state not cleared after last item");

    // an escape is only ever open in the path, query or fragment
    a_esc_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.esc != ESC_NONE |-> st_reg.phase == PH_PATH || st_reg.phase == PH_QUERY ||
                                   st_reg.phase == PH_FRAG)
        else $error("escape open outside a section");

endmodule

`default_nettype wire
